### design/hpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared widths and register codes of the homogeneous point transform core.
// ----------------------------------------------------------------------------
package hpt_pkg;

	localparam int COORD_W   = 48;  // signed coordinate width
	localparam int COEF_W    = 32;  // signed coefficient width (one half register)
	localparam int CFG_W     = 64;  // configuration register width
	localparam int NUM_REGS  = 8;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_OUT   = 4;   // x, y, z, w rows
	localparam int NUM_IN    = 3;   // x, y, z inputs
	localparam int TDATA_W   = 3 * COORD_W;
	localparam int TUSER_W   = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_XIN_TO_XY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_XIN_TO_ZW = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_YIN_TO_XY = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_YIN_TO_ZW = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ZIN_TO_XY = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ZIN_TO_ZW = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_XY = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_ZW = 3'd7;

	// tuser bit positions on the result side
	localparam int TUSER_FAULT = 0;
	localparam int TUSER_SAT   = 1;

	typedef logic [CFG_W-1:0] cfg_word_t;

endpackage : hpt_pkg
`default_nettype wire

### design/homogeneous_point_transform_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// homogeneous_point_transform_core
// 4x4 homogeneous transform of a Q31.16 point with perspective divide,
// saturation to 48 bits and a divide-by-zero fault flag.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake                  Payload
// s_axis   in   s_axis_tvalid/tready       tdata = in_x, in_y, in_z
// m_axis   out  m_axis_tvalid/tready       tdata = out_x, out_y, out_z;
//                                          tuser = divide_fault, saturated
// cfg      in   cfg_wen                    cfg_index, cfg_data (no read-back)
//
// One point enters per cycle while the output is not held; the pipeline has 2 multiply stages,
// 2 add stages, 1 setup stage, 1 + 48 restoring-divider stages (one quotient bit each,
// three dividers in parallel sharing the divisor) and the output register.
// Reset clears valid bits and loads the identity matrix.
// The whole pipeline advances together: it holds only while the output
// register is full and the sink does not take it, so nothing is dropped.
// ----------------------------------------------------------------------------
module homogeneous_point_transform_core #(
	parameter int COORD_FRAC_BITS = 16,
	parameter int COEF_FRAC_BITS  = 16
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// configuration write port
	input  wire                                   cfg_wen,
	input  wire  [hpt_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire  [hpt_pkg::CFG_W-1:0]             cfg_data,
	// input points
	input  wire                                   s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire  [hpt_pkg::TDATA_W-1:0]           s_axis_tdata,  // in_x, in_y, in_z
	// results
	output logic                                  m_axis_tvalid,
	input  wire                                   m_axis_tready,
	output logic [hpt_pkg::TDATA_W-1:0]           m_axis_tdata,  // out_x, out_y, out_z
	output logic [hpt_pkg::TUSER_W-1:0]           m_axis_tuser   // divide_fault, saturated
);

	import hpt_pkg::*;

	localparam int PLO_W  = 65;                 // {0,x[31:0]} * coef
	localparam int PHI_W  = 48;                 // x[47:32] * coef
	localparam int PROD_W = COORD_W + COEF_W;   // exact product / term width
	localparam int PAIR_W = PROD_W + 1;
	localparam int SUM_W  = PROD_W + 2;
	localparam int DEN_W  = SUM_W;
	localparam int NUM_W  = SUM_W + COORD_FRAC_BITS;
	localparam int QW     = COORD_W;            // quotient bits kept

	localparam logic [QW-1:0] MAG_MAX = {1'b0, {(QW-1){1'b1}}};
	localparam logic [QW-1:0] MAG_MIN = {1'b1, {(QW-1){1'b0}}};
	localparam logic [SUM_W-1:0] W_ONE = SUM_W'(1) << COORD_FRAC_BITS;

	// ------------------------------------------------------------------
	// Configuration registers (identity after reset)
	// ------------------------------------------------------------------
	cfg_word_t cfg_q [0:NUM_REGS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[REG_XIN_TO_XY] <= CFG_W'(1) << COEF_FRAC_BITS;
			cfg_q[REG_XIN_TO_ZW] <= '0;
			cfg_q[REG_YIN_TO_XY] <= CFG_W'(1) << (COEF_FRAC_BITS + COEF_W);
			cfg_q[REG_YIN_TO_ZW] <= '0;
			cfg_q[REG_ZIN_TO_XY] <= '0;
			cfg_q[REG_ZIN_TO_ZW] <= CFG_W'(1) << COEF_FRAC_BITS;
			cfg_q[REG_OFFSET_XY] <= '0;
			cfg_q[REG_OFFSET_ZW] <= CFG_W'(1) << (COEF_FRAC_BITS + COEF_W);
		end else if (cfg_wen) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// Row o (x,y,z,w) weight of input j lives in register 2*j + o/2,
	// low half for even rows, high half for odd rows.
	function automatic logic [COEF_W-1:0] coef_of(input cfg_word_t r, input int o);
		coef_of = (o % 2 == 1) ? r[CFG_W-1:COEF_W] : r[COEF_W-1:0];
	endfunction

	// ------------------------------------------------------------------
	// Pipeline advance: everything moves unless the output is held.
	// ------------------------------------------------------------------
	logic adv;
	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// ------------------------------------------------------------------
	// Stage 1: partial products (48-bit coordinate split 16 + 32)
	// ------------------------------------------------------------------
	logic                    v_s1;
	logic signed [PLO_W-1:0] plo_s1 [0:NUM_OUT-1][0:NUM_IN-1];
	logic signed [PHI_W-1:0] phi_s1 [0:NUM_OUT-1][0:NUM_IN-1];
	logic [COEF_W-1:0]       off_s1 [0:NUM_OUT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int o = 0; o < NUM_OUT; o++) begin
				for (int j = 0; j < NUM_IN; j++) begin
					plo_s1[o][j] <= $signed({1'b0, s_axis_tdata[j*COORD_W +: 32]}) *
						$signed(coef_of(cfg_q[2*j + o/2], o));
					phi_s1[o][j] <= $signed(s_axis_tdata[j*COORD_W + 32 +: 16]) *
						$signed(coef_of(cfg_q[2*j + o/2], o));
				end
				off_s1[o] <= coef_of(cfg_q[REG_OFFSET_XY + CFG_IDX_W'(o/2)], o);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: exact products, arithmetic shift to coordinate scale
	// ------------------------------------------------------------------
	logic                     v_s2;
	logic signed [PROD_W-1:0] term_s2 [0:NUM_OUT-1][0:NUM_IN];
	logic signed [PROD_W-1:0] prod_c  [0:NUM_OUT-1][0:NUM_IN];

	always_comb begin
		for (int o = 0; o < NUM_OUT; o++) begin
			for (int j = 0; j < NUM_IN; j++) begin
				prod_c[o][j] = $signed({phi_s1[o][j], 32'd0}) +
					$signed({{(PROD_W-PLO_W){plo_s1[o][j][PLO_W-1]}}, plo_s1[o][j]});
			end
			// translation: coef * 1.0 in coordinate format
			prod_c[o][NUM_IN] = $signed({{(PROD_W-COEF_W){off_s1[o][COEF_W-1]}}, off_s1[o]})
				<<< COORD_FRAC_BITS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int o = 0; o < NUM_OUT; o++)
				for (int j = 0; j <= NUM_IN; j++)
					term_s2[o][j] <= prod_c[o][j] >>> COEF_FRAC_BITS;
		end
	end

	// ------------------------------------------------------------------
	// Stages 3 and 4: adder tree per row
	// ------------------------------------------------------------------
	logic                     v_s3, v_s4;
	logic signed [PAIR_W-1:0] pair_s3 [0:NUM_OUT-1][0:1];
	logic signed [SUM_W-1:0]  sum_s4  [0:NUM_OUT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int o = 0; o < NUM_OUT; o++) begin
				pair_s3[o][0] <= PAIR_W'(term_s2[o][0]) + PAIR_W'(term_s2[o][1]);
				pair_s3[o][1] <= PAIR_W'(term_s2[o][2]) + PAIR_W'(term_s2[o][3]);
				sum_s4[o]     <= SUM_W'(pair_s3[o][0]) + SUM_W'(pair_s3[o][1]);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: divider setup. w == 1 passes the sum through as sum / 1,
	// w == 0 divides zero by one and raises the fault.
	// ------------------------------------------------------------------
	logic               v_s5;
	logic               fault_s5;
	logic [DEN_W-1:0]   den_s5;
	logic [NUM_W-1:0]   num_s5 [0:NUM_IN-1];
	logic               neg_s5 [0:NUM_IN-1];

	logic               w_zero, w_one, w_neg;
	logic [DEN_W-1:0]   w_mag;
	logic [SUM_W-1:0]   s_mag [0:NUM_IN-1];

	always_comb begin
		w_zero = (sum_s4[3] == '0);
		w_one  = (sum_s4[3] == W_ONE);
		w_neg  = sum_s4[3][SUM_W-1];
		w_mag  = w_neg ? DEN_W'(-sum_s4[3]) : DEN_W'(sum_s4[3]);
		for (int i = 0; i < NUM_IN; i++)
			s_mag[i] = sum_s4[i][SUM_W-1] ? SUM_W'(-sum_s4[i]) : SUM_W'(sum_s4[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fault_s5 <= w_zero;
			den_s5   <= (w_zero || w_one) ? DEN_W'(1) : w_mag;
			for (int i = 0; i < NUM_IN; i++) begin
				if (w_zero) begin
					num_s5[i] <= '0;
					neg_s5[i] <= 1'b0;
				end else if (w_one) begin
					num_s5[i] <= NUM_W'(s_mag[i]);
					neg_s5[i] <= sum_s4[i][SUM_W-1];
				end else begin
					num_s5[i] <= NUM_W'(s_mag[i]) << COORD_FRAC_BITS;
					neg_s5[i] <= sum_s4[i][SUM_W-1] ^ w_neg;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Divider: stage 0 flags a quotient of 2^48 or more, stages 1..QW
	// each produce one quotient bit, most significant first.
	// ------------------------------------------------------------------
	logic             dv_v_sd     [0:QW];
	logic             dv_fault_sd [0:QW];
	logic [DEN_W-1:0] dv_den_sd   [0:QW];
	logic [NUM_W-1:0] dv_num_sd   [0:NUM_IN-1][0:QW];
	logic [DEN_W-1:0] dv_rem_sd   [0:NUM_IN-1][0:QW];
	logic [QW-1:0]    dv_q_sd     [0:NUM_IN-1][0:QW];
	logic             dv_neg_sd   [0:NUM_IN-1][0:QW];
	logic             dv_ovf_sd   [0:NUM_IN-1][0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v_sd[0] <= 1'b0;
		else if (adv) dv_v_sd[0] <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_fault_sd[0] <= fault_s5;
			dv_den_sd[0]   <= den_s5;
			for (int i = 0; i < NUM_IN; i++) begin
				dv_num_sd[i][0] <= num_s5[i];
				dv_rem_sd[i][0] <= DEN_W'(num_s5[i][NUM_W-1:QW]);
				dv_q_sd[i][0]   <= '0;
				dv_neg_sd[i][0] <= neg_s5[i];
				dv_ovf_sd[i][0] <= (DEN_W'(num_s5[i][NUM_W-1:QW]) >= den_s5);
			end
		end
	end

	genvar k, c;
	generate
		for (k = 1; k <= QW; k++) begin : g_div
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) dv_v_sd[k] <= 1'b0;
				else if (adv) dv_v_sd[k] <= dv_v_sd[k-1];
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					dv_fault_sd[k] <= dv_fault_sd[k-1];
					dv_den_sd[k]   <= dv_den_sd[k-1];
				end
			end

			for (c = 0; c < NUM_IN; c++) begin : g_lane
				logic [DEN_W:0] trial;
				logic [DEN_W:0] diff;
				logic           ge;

				// bring down the next numerator bit, subtract when it fits
				assign trial = {dv_rem_sd[c][k-1], dv_num_sd[c][k-1][QW-k]};
				assign diff  = trial - {1'b0, dv_den_sd[k-1]};
				assign ge    = !diff[DEN_W];

				always_ff @(posedge clk) begin
					if (adv) begin
						dv_num_sd[c][k] <= dv_num_sd[c][k-1];
						dv_rem_sd[c][k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
						dv_q_sd[c][k]   <= {dv_q_sd[c][k-1][QW-2:0], ge};
						dv_neg_sd[c][k] <= dv_neg_sd[c][k-1];
						dv_ovf_sd[c][k] <= dv_ovf_sd[c][k-1];
					end
				end
			end
		end
	endgenerate

	// ------------------------------------------------------------------
	// Output register: sign, saturate, flags
	// ------------------------------------------------------------------
	logic [QW-1:0] res_c [0:NUM_IN-1];
	logic          sat_c [0:NUM_IN-1];

	always_comb begin
		for (int i = 0; i < NUM_IN; i++) begin
			if (dv_neg_sd[i][QW]) begin
				sat_c[i] = dv_ovf_sd[i][QW] || (dv_q_sd[i][QW] > MAG_MIN);
				res_c[i] = sat_c[i] ? MAG_MIN : QW'(-dv_q_sd[i][QW]);
			end else begin
				sat_c[i] = dv_ovf_sd[i][QW] || dv_q_sd[i][QW][QW-1];
				res_c[i] = sat_c[i] ? MAG_MAX : dv_q_sd[i][QW];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (adv) m_axis_tvalid <= dv_v_sd[QW];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NUM_IN; i++)
				m_axis_tdata[i*COORD_W +: COORD_W] <= res_c[i];
			m_axis_tuser[TUSER_FAULT] <= dv_fault_sd[QW];
			m_axis_tuser[TUSER_SAT]   <= sat_c[0] || sat_c[1] || sat_c[2];
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// a zero w gives zero coordinates and no saturation
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[TUSER_FAULT] |->
			(m_axis_tdata == '0) && !m_axis_tuser[TUSER_SAT])
		else $error("fault result not cleared");

	// back-pressure comes only from a held output
	a_ready_src: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output stall");

	// a saturated result has at least one coordinate at a range limit
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[TUSER_SAT] |->
			m_axis_tdata[47:0] == MAG_MAX || m_axis_tdata[47:0] == MAG_MIN ||
			m_axis_tdata[95:48] == MAG_MAX || m_axis_tdata[95:48] == MAG_MIN ||
			m_axis_tdata[143:96] == MAG_MAX || m_axis_tdata[143:96] == MAG_MIN)
		else $error("saturated flag without clamped coordinate");

	// a held pipeline keeps the output valid
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result lost under stall");

endmodule : homogeneous_point_transform_core
`default_nettype wire
